@@ src/i2c_ee_pkg.sv @@
// shared types, constants and helpers for the two-wire serial eeprom slave
// no dependencies; used by every other file of the block but i2c_ee_outbuf
`default_nettype none

package i2c_ee_pkg;

  // default sizes, powers of two
  localparam int MEM_BYTES_DEF     = 65536;
  localparam int ID_PAGE_BYTES_DEF = 64;

  // configuration register map
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_TYPE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_EN    = 4'd1;

  // device byte areas and part types
  localparam logic [3:0] AREA_MEM        = 4'hA;
  localparam logic [3:0] AREA_ID         = 4'hB;
  localparam logic [3:0] TYPE_NONE       = 4'd0;
  localparam logic [3:0] TYPE_SEVEN      = 4'd1;
  localparam logic [3:0] TYPE_LAST_SMALL = 4'd6;
  localparam logic [3:0] TYPE_MAX        = 4'd12;

  localparam int OFF_W = 16;

  typedef enum logic [2:0] {
    PH_STANDBY = 3'd0,
    PH_DEVICE  = 3'd1,
    PH_BANK    = 3'd2,
    PH_ADDRESS = 3'd3,
    PH_READ    = 3'd4,
    PH_WRITE   = 3'd5
  } phase_t;

  // request from the protocol engine to the stores, at most one access per item
  typedef struct packed {
    logic             rd_main;
    logic             rd_id;
    logic             wr_main;
    logic             wr_id;
    logic [OFF_W-1:0] addr;
    logic [7:0]       id_addr;
    logic [7:0]       wdata;
  } mem_req_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } mem_rsp_t;

  // offset mask for each known part type, type none handled by the caller
  function automatic logic [OFF_W-1:0] part_mask(input logic [3:0] kind);
    logic [OFF_W-1:0] m;
    unique case (kind)
      4'd1, 4'd2: m = 16'h007F;
      4'd3:       m = 16'h00FF;
      4'd4:       m = 16'h01FF;
      4'd5:       m = 16'h03FF;
      4'd6:       m = 16'h07FF;
      4'd7:       m = 16'h0FFF;
      4'd8, 4'd9: m = 16'h1FFF;
      4'd10:      m = 16'h3FFF;
      4'd11:      m = 16'h7FFF;
      4'd12:      m = 16'hFFFF;
      default:    m = 16'hFFFF;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

@@ src/i2c_ee_intf.sv @@
// valid/ready channel interfaces for line samples, drive results and config writes
// depends on i2c_ee_pkg for config widths
`default_nettype none

interface i2c_ee_in_if;
  logic valid;
  logic ready;
  logic scl;
  logic sda;
  modport source (output valid, scl, sda, input ready);
  modport sink   (input valid, scl, sda, output ready);
endinterface

interface i2c_ee_out_if;
  logic valid;
  logic ready;
  logic sda_drive;
  modport source (output valid, sda_drive, input ready);
  modport sink   (input valid, sda_drive, output ready);
endinterface

interface i2c_ee_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [i2c_ee_pkg::CFG_IDX_W-1:0]  idx;
  logic [i2c_ee_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, idx, data, input ready);
  modport sink   (input valid, idx, data, output ready);
endinterface

`default_nettype wire

@@ src/i2c_ee_mem.sv @@
// main store and id page store, synchronous, with registered read data
// depends on i2c_ee_pkg; main store is swept to erased after reset
`default_nettype none

module i2c_ee_mem #(
  parameter int MEM_BYTES     = i2c_ee_pkg::MEM_BYTES_DEF,
  parameter int ID_PAGE_BYTES = i2c_ee_pkg::ID_PAGE_BYTES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire i2c_ee_pkg::mem_req_t req,
  output i2c_ee_pkg::mem_rsp_t      rsp,
  output logic                      clr_busy
);

  localparam int MAW = $clog2(MEM_BYTES);
  localparam int IAW = $clog2(ID_PAGE_BYTES);
  localparam logic [MAW-1:0] CLR_LAST = MAW'(MEM_BYTES - 1);

  logic [7:0] main_mem [MEM_BYTES];
  logic [7:0] id_mem   [ID_PAGE_BYTES];

  logic [ID_PAGE_BYTES-1:0] id_vld_r;
  logic [MAW-1:0]           clr_cnt_r;
  logic                     clr_busy_r;
  logic [7:0]               main_q_r;
  logic [7:0]               id_q_r;
  logic                     id_hit_r;
  logic                     sel_id_r;
  logic                     rsp_vld_r;

  logic [MAW-1:0] main_idx;
  logic [IAW-1:0] id_idx;

  assign main_idx = req.addr[MAW-1:0];
  assign id_idx   = req.id_addr[IAW-1:0];

  // main store: erase sweep has the write port until done
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      main_mem[clr_cnt_r] <= 8'hFF;
    end else if (req.wr_main) begin
      main_mem[main_idx] <= req.wdata;
    end
    if (req.rd_main) begin
      main_q_r <= main_mem[main_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_id) begin
      id_mem[id_idx] <= req.wdata;
    end
    if (req.rd_id) begin
      id_q_r <= id_mem[id_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      clr_busy_r <= 1'b1;
      id_vld_r   <= '0;
      rsp_vld_r  <= 1'b0;
      sel_id_r   <= 1'b0;
      id_hit_r   <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_r + MAW'(1);
        if (clr_cnt_r == CLR_LAST) begin
          clr_busy_r <= 1'b0;
        end
      end
      if (req.wr_id) begin
        id_vld_r[id_idx] <= 1'b1;
      end
      rsp_vld_r <= req.rd_main | req.rd_id;
      if (req.rd_main | req.rd_id) begin
        sel_id_r <= req.rd_id;
      end
      if (req.rd_id) begin
        id_hit_r <= id_vld_r[id_idx];
      end
    end
  end

  // never-written id entries read as erased
  assign rsp.valid = rsp_vld_r;
  assign rsp.data  = sel_id_r ? (id_hit_r ? id_q_r : 8'hFF) : main_q_r;
  assign clr_busy  = clr_busy_r;

endmodule

`default_nettype wire

@@ src/i2c_ee_ctrl.sv @@
// bus protocol engine: start/stop detect, bit counting, byte shifting, store requests
// depends on i2c_ee_pkg; drives i2c_ee_mem and the output buffer
`default_nettype none

module i2c_ee_ctrl #(
  parameter int MEM_BYTES = i2c_ee_pkg::MEM_BYTES_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                accept,
  input  wire logic                                scl,
  input  wire logic                                sda,
  input  wire logic                                cfg_wr,
  input  wire logic [i2c_ee_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [i2c_ee_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire i2c_ee_pkg::mem_rsp_t                rsp,
  output i2c_ee_pkg::mem_req_t                     req,
  output logic                                     drive
);

  localparam logic [i2c_ee_pkg::OFF_W-1:0] MEM_MASK = i2c_ee_pkg::OFF_W'(MEM_BYTES - 1);

  logic [3:0] dev_type_r;
  logic       wr_en_r;

  i2c_ee_pkg::phase_t phase_r, phase_nxt;
  logic       prev_scl_r, prev_sda_r;
  logic [3:0] bc_r, bc_nxt;
  logic [7:0] db_r, db_nxt;
  logic [7:0] ha_r, ha_nxt;
  logic [7:0] la_r, la_nxt;
  logic [7:0] ws_r, ws_nxt;
  logic [7:0] rb_r;
  logic       ack_r, ack_nxt;
  logic       lock_r, lock_nxt;

  logic [3:0] kind;
  logic       small_part, seven, rise, fall, area_mem, area_id;
  logic [7:0] la_adv, ha_adv;
  logic [i2c_ee_pkg::OFF_W-1:0] mask, idx_cur, idx_adv;
  i2c_ee_pkg::mem_req_t req_c;

  function automatic logic [i2c_ee_pkg::OFF_W-1:0] offset(
    input logic       sev, input logic sm,
    input logic [7:0] d,   input logic [7:0] h, input logic [7:0] l);
    logic [i2c_ee_pkg::OFF_W-1:0] o;
    if (sev) o = {9'd0, l[7:1]};
    else if (sm) o = {1'b0, d[7:1], l};
    else o = {h, l};
    return o;
  endfunction

  always_comb begin
    kind       = (dev_type_r > i2c_ee_pkg::TYPE_MAX) ? i2c_ee_pkg::TYPE_NONE : dev_type_r;
    small_part = kind <= i2c_ee_pkg::TYPE_LAST_SMALL;
    seven      = kind == i2c_ee_pkg::TYPE_SEVEN;
    mask       = (kind == i2c_ee_pkg::TYPE_NONE) ? MEM_MASK : i2c_ee_pkg::part_mask(kind);
    area_mem   = db_r[7:4] == i2c_ee_pkg::AREA_MEM;
    area_id    = db_r[7:4] == i2c_ee_pkg::AREA_ID;
    la_adv     = la_r + (seven ? 8'd2 : 8'd1);
    ha_adv     = (la_adv == 8'd0) ? ha_r + 8'd1 : ha_r;
    idx_cur    = offset(seven, small_part, db_r, ha_r, la_r) & mask;
    idx_adv    = offset(seven, small_part, db_r, ha_adv, la_adv) & mask;
    rise       = !prev_scl_r && scl;
    fall       = prev_scl_r && !scl;

    phase_nxt = phase_r;
    bc_nxt    = bc_r;
    db_nxt    = db_r;
    ha_nxt    = ha_r;
    la_nxt    = la_r;
    ws_nxt    = ws_r;
    ack_nxt   = ack_r;
    lock_nxt  = lock_r;
    req_c     = '0;
    req_c.addr    = idx_cur;
    req_c.id_addr = la_r;
    req_c.wdata   = ws_r;

    // start and stop
    if (scl) begin
      if (prev_sda_r && !sda) begin
        bc_nxt    = 4'd0;
        phase_nxt = seven ? i2c_ee_pkg::PH_ADDRESS : i2c_ee_pkg::PH_DEVICE;
      end else if (!prev_sda_r && sda) begin
        bc_nxt    = 4'd0;
        phase_nxt = i2c_ee_pkg::PH_STANDBY;
      end
    end

    if (fall) begin
      bc_nxt = (bc_nxt > 4'd8) ? 4'd1 : bc_nxt + 4'd1;
    end

    if (rise) begin
      unique case (phase_r)
        i2c_ee_pkg::PH_DEVICE: begin
          if (bc_nxt <= 4'd8) begin
            db_nxt = {db_r[6:0], sda};
          end else if (!(area_mem || (area_id && !small_part))) begin
            phase_nxt = i2c_ee_pkg::PH_STANDBY;
          end else if (db_r[0]) begin
            phase_nxt     = i2c_ee_pkg::PH_READ;
            ack_nxt       = 1'b0;
            req_c.rd_main = area_mem;
            req_c.rd_id   = !area_mem;
          end else begin
            phase_nxt = small_part ? i2c_ee_pkg::PH_ADDRESS : i2c_ee_pkg::PH_BANK;
            ack_nxt   = 1'b0;
          end
        end
        i2c_ee_pkg::PH_BANK: begin
          if (bc_nxt <= 4'd8) begin
            ha_nxt = {ha_r[6:0], sda};
          end else begin
            phase_nxt = i2c_ee_pkg::PH_ADDRESS;
            ack_nxt   = 1'b0;
          end
        end
        i2c_ee_pkg::PH_ADDRESS: begin
          if (bc_nxt <= 4'd8) begin
            la_nxt = {la_r[6:0], sda};
          end else if (seven && la_r[0]) begin
            phase_nxt = i2c_ee_pkg::PH_READ;
            if (area_mem) begin
              ack_nxt       = 1'b0;
              req_c.rd_main = 1'b1;
            end else if (area_id && !small_part) begin
              ack_nxt     = 1'b0;
              req_c.rd_id = 1'b1;
            end else begin
              ack_nxt = 1'b1;
            end
          end else begin
            phase_nxt = i2c_ee_pkg::PH_WRITE;
            ack_nxt   = 1'b0;
          end
        end
        i2c_ee_pkg::PH_READ: begin
          if (bc_nxt <= 4'd8) begin
            ack_nxt = (bc_nxt == 4'd0) ? 1'b0 : rb_r[3'(4'd8 - bc_nxt)];
          end else if (!sda) begin
            la_nxt        = la_adv;
            ha_nxt        = ha_adv;
            req_c.addr    = idx_adv;
            req_c.id_addr = la_adv;
            if (area_mem) begin
              ack_nxt       = 1'b0;
              req_c.rd_main = 1'b1;
            end else if (area_id && !small_part) begin
              ack_nxt     = 1'b0;
              req_c.rd_id = 1'b1;
            end else begin
              ack_nxt = 1'b1;
            end
          end else begin
            phase_nxt = i2c_ee_pkg::PH_STANDBY;
          end
        end
        i2c_ee_pkg::PH_WRITE: begin
          if (bc_nxt <= 4'd8) begin
            ws_nxt = {ws_r[6:0], sda};
          end else begin
            la_nxt = la_adv;
            ha_nxt = ha_adv;
            if (area_mem) begin
              ack_nxt       = !wr_en_r;
              req_c.wr_main = wr_en_r;
            end else if (area_id) begin
              if (!wr_en_r || small_part) begin
                ack_nxt = 1'b1;
              end else if (ha_r[2]) begin
                // lock store: bit 10 of the word address
                lock_nxt = lock_r | ws_r[1];
                ack_nxt  = 1'b0;
              end else if (lock_r) begin
                ack_nxt = 1'b1;
              end else begin
                ack_nxt     = 1'b0;
                req_c.wr_id = 1'b1;
              end
            end else begin
              ack_nxt = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end

    req = req_c;
    if (!accept) begin
      req.rd_main = 1'b0;
      req.rd_id   = 1'b0;
      req.wr_main = 1'b0;
      req.wr_id   = 1'b0;
    end
    drive = (phase_nxt == i2c_ee_pkg::PH_STANDBY) ? sda : ack_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_type_r <= i2c_ee_pkg::TYPE_NONE;
      wr_en_r    <= 1'b1;
      phase_r    <= i2c_ee_pkg::PH_STANDBY;
      prev_scl_r <= 1'b0;
      prev_sda_r <= 1'b0;
      bc_r       <= 4'd0;
      db_r       <= {i2c_ee_pkg::AREA_MEM, 4'h0};
      ha_r       <= 8'd0;
      la_r       <= 8'd0;
      ws_r       <= 8'd0;
      rb_r       <= 8'd0;
      ack_r      <= 1'b0;
      lock_r     <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_idx)
          i2c_ee_pkg::CFG_DEVICE_TYPE: dev_type_r <= cfg_data;
          i2c_ee_pkg::CFG_WRITE_EN:    wr_en_r    <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (accept) begin
        phase_r    <= phase_nxt;
        prev_scl_r <= scl;
        prev_sda_r <= sda;
        bc_r       <= bc_nxt;
        db_r       <= db_nxt;
        ha_r       <= ha_nxt;
        la_r       <= la_nxt;
        ws_r       <= ws_nxt;
        ack_r      <= ack_nxt;
        lock_r     <= lock_nxt;
      end
      // read data from the store response is registered into rb_r, well before the next rising scl sample
      if (rsp.valid) begin
        rb_r <= rsp.data;
      end
    end
  end

endmodule

`default_nettype wire

@@ src/i2c_ee_outbuf.sv @@
// two-entry output buffer: output register plus skid entry
// depends on i2c_ee_intf for the result channel
`default_nettype none

module i2c_ee_outbuf (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire logic    push_data,
  output logic         full,
  i2c_ee_out_if.source out_ch
);

  logic out_vld_r, out_dat_r, skid_vld_r, skid_dat_r;
  logic out_vld_nxt, skid_vld_nxt;
  logic pop;

  assign pop = out_vld_r && out_ch.ready;

  // skid entry drains into the output register first
  always_comb begin
    out_vld_nxt  = out_vld_r;
    skid_vld_nxt = skid_vld_r;
    if (pop) begin
      if (skid_vld_r) begin
        skid_vld_nxt = 1'b0;
      end else begin
        out_vld_nxt = 1'b0;
      end
    end
    if (push) begin
      if (out_vld_r && !pop) begin
        skid_vld_nxt = 1'b1;
      end else begin
        out_vld_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && skid_vld_r) begin
      out_dat_r <= skid_dat_r;
    end
    if (push) begin
      if (out_vld_r && !pop) begin
        skid_dat_r <= push_data;
      end else begin
        out_dat_r <= push_data;
      end
    end
  end

  assign full             = skid_vld_r;
  assign out_ch.valid     = out_vld_r;
  assign out_ch.sda_drive = out_dat_r;

endmodule

`default_nettype wire

@@ src/i2c_serial_eeprom_slave_top.sv @@
// top level of the two-wire serial eeprom slave
// depends on i2c_ee_pkg, i2c_ee_intf, i2c_ee_mem, i2c_ee_ctrl, i2c_ee_outbuf
`default_nettype none

// Serial eeprom slave for a 24Cxx-style two-wire bus. Each input transfer is
// one sample of scl and sda; each one yields exactly one result transfer with
// the level the device drives on sda (it follows sda in standby, otherwise it
// is the acknowledge or read data bit). One sample is taken per clock cycle
// while in_if.ready is high: the protocol engine updates all of its state and
// issues at most one access to the stores, so samples may follow back to back.
// The result is registered in the output register, or in the skid entry while
// the output is stalled; the skid entry lets one more sample in. The stores
// are synchronous memories with registered read data; fetched data lands in
// the read data register before the next rising scl sample can use it. After
// reset the main store is swept to erased, one byte per cycle, over all
// MEM_BYTES bytes (65536 by default); in_if.ready stays low during the sweep
// while configuration writes are taken at any time. The id page uses per-byte
// valid bits so unwritten bytes read as erased. Both sizes are powers of two.
// Configuration: register 0 device type (0 none, 1 seven-bit addressing part,
// 2..12 parts by size, 13..15 act as none), register 1 write enable. Write
// configuration only while no sample is in flight.
module i2c_serial_eeprom_slave_top #(
  parameter int MEM_BYTES     = i2c_ee_pkg::MEM_BYTES_DEF,
  parameter int ID_PAGE_BYTES = i2c_ee_pkg::ID_PAGE_BYTES_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  i2c_ee_in_if.sink    in_if,
  i2c_ee_out_if.source out_if,
  i2c_ee_cfg_if.sink   cfg_if
);

  i2c_ee_pkg::mem_req_t mem_req;
  i2c_ee_pkg::mem_rsp_t mem_rsp;
  logic clr_busy;   // erase sweep running
  logic ob_full;    // skid entry occupied
  logic in_xfer;    // input transfer this cycle
  logic cfg_xfer;   // config transfer this cycle
  logic drive;      // drive level of the accepted sample

  // config port never stalls
  assign cfg_if.ready = 1'b1;
  assign cfg_xfer     = cfg_if.valid && cfg_if.ready;

  // a sample is taken whenever the sweep is done and the buffer has room
  assign in_if.ready = !clr_busy && !ob_full;
  assign in_xfer     = in_if.valid && in_if.ready;

  i2c_ee_mem #(
    .MEM_BYTES     (MEM_BYTES),
    .ID_PAGE_BYTES (ID_PAGE_BYTES)
  ) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (mem_req),
    .rsp      (mem_rsp),
    .clr_busy (clr_busy)
  );

  i2c_ee_ctrl #(
    .MEM_BYTES (MEM_BYTES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_xfer),
    .scl      (in_if.scl),
    .sda      (in_if.sda),
    .cfg_wr   (cfg_xfer),
    .cfg_idx  (cfg_if.idx),
    .cfg_data (cfg_if.data),
    .rsp      (mem_rsp),
    .req      (mem_req),
    .drive    (drive)
  );

  // output register plus skid entry
  i2c_ee_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_xfer),
    .push_data (drive),
    .full      (ob_full),
    .out_ch    (out_if)
  );

`ifndef SYNTHESIS
  // no sample may slip in while the main store is being erased
  a_no_xfer_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |-> !clr_busy)
    else $error("input transfer during erase sweep");

  // every accepted sample has a result waiting the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> out_if.valid)
    else $error("no result after accepted sample");

  // at most one store access per sample
  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({mem_req.rd_main, mem_req.rd_id, mem_req.wr_main, mem_req.wr_id}))
    else $error("more than one store access in a cycle");

  // read data only comes back for a fetch issued the cycle before
  a_rsp_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    mem_rsp.valid |-> $past(mem_req.rd_main || mem_req.rd_id))
    else $error("read data without a fetch");
`endif

endmodule

`default_nettype wire
